// ----- hdl/stt_pkg.sv -----
// Shared types, codes and character helpers for the source text tokenizer.
// No dependencies; imported by stt_scan and source_text_tokenizer_unit.
`default_nettype none

package stt_pkg;

  // parameter defaults
  localparam int OFFSET_BITS_DEF   = 16;
  localparam int KEYWORD_CHARS_DEF = 8;

  // token kinds
  localparam logic [5:0] K_END    = 6'd0;
  localparam logic [5:0] K_LPAREN = 6'd1;
  localparam logic [5:0] K_RPAREN = 6'd2;
  localparam logic [5:0] K_LBRACE = 6'd3;
  localparam logic [5:0] K_RBRACE = 6'd4;
  localparam logic [5:0] K_ADD    = 6'd5;
  localparam logic [5:0] K_SUB    = 6'd6;
  localparam logic [5:0] K_ARROW  = 6'd7;
  localparam logic [5:0] K_MUL    = 6'd8;
  localparam logic [5:0] K_DIV    = 6'd9;
  localparam logic [5:0] K_MOD    = 6'd10;
  localparam logic [5:0] K_DOT    = 6'd11;
  localparam logic [5:0] K_SEMI   = 6'd12;
  localparam logic [5:0] K_COLON  = 6'd13;
  localparam logic [5:0] K_COMMA  = 6'd14;
  localparam logic [5:0] K_AND    = 6'd15;
  localparam logic [5:0] K_OR     = 6'd16;
  localparam logic [5:0] K_LE     = 6'd17;
  localparam logic [5:0] K_LT     = 6'd18;
  localparam logic [5:0] K_GE     = 6'd19;
  localparam logic [5:0] K_GT     = 6'd20;
  localparam logic [5:0] K_EQEQ   = 6'd21;
  localparam logic [5:0] K_ASSIGN = 6'd22;
  localparam logic [5:0] K_NE     = 6'd23;
  localparam logic [5:0] K_NOT    = 6'd24;
  localparam logic [5:0] K_INT    = 6'd25;
  localparam logic [5:0] K_IDENT  = 6'd26;
  localparam logic [5:0] K_KEY0   = 6'd27;

  // error codes
  localparam logic [2:0] E_NONE = 3'd0;
  localparam logic [2:0] E_BAD  = 3'd1;
  localparam logic [2:0] E_LONE = 3'd2;
  localparam logic [2:0] E_OPEN = 3'd3;
  localparam logic [2:0] E_OVF  = 3'd4;

  // scanning modes, one-hot
  typedef enum logic [13:0] {
    M_IDLE  = 14'h0001,
    M_MINUS = 14'h0002,
    M_LT    = 14'h0004,
    M_GT    = 14'h0008,
    M_EQ    = 14'h0010,
    M_BANG  = 14'h0020,
    M_AMP   = 14'h0040,
    M_BAR   = 14'h0080,
    M_SLASH = 14'h0100,
    M_LINE  = 14'h0200,
    M_BLOCK = 14'h0400,
    M_BSTAR = 14'h0800,
    M_NUM   = 14'h1000,
    M_WORD  = 14'h2000
  } mode_e;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [30:0] literal_value;
    logic [2:0]  error_code;
    logic        last_result;
  } out_t;

  // up to three words caused by one character
  typedef struct packed {
    out_t [2:0] res;
    logic [1:0] cnt;
  } res_set_t;

  // keywords, right-aligned with the first character highest
  localparam logic [63:0] KW_TEXT [16] = '{
    64'("void"), 64'("bool"), 64'("int"), 64'("true"), 64'("false"),
    64'("let"), 64'("var"), 64'("if"), 64'("else"), 64'("for"),
    64'("while"), 64'("continue"), 64'("break"), 64'("return"),
    64'("extern"), 64'("func")};
  localparam logic [3:0] KW_LEN [16] = '{
    4'd4, 4'd4, 4'd3, 4'd4, 4'd5, 4'd3, 4'd3, 4'd2,
    4'd4, 4'd3, 4'd5, 4'd8, 4'd5, 4'd6, 4'd6, 4'd4};

  function automatic logic [5:0] kw_kind(logic [63:0] w, logic [15:0] len);
    logic [5:0] k;
    k = K_IDENT;
    for (int i = 15; i >= 0; i--) begin
      if (len == 16'(KW_LEN[i]) && w == KW_TEXT[i]) begin
        k = K_KEY0 + 6'(i);
      end
    end
    return k;
  endfunction

  function automatic logic [15:0] sat16(logic [32:0] v);
    return (v > 33'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic [5:0] single_kind(logic [7:0] c);
    logic [5:0] k;
    case (c)
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      "{":     k = K_LBRACE;
      "}":     k = K_RBRACE;
      "+":     k = K_ADD;
      "*":     k = K_MUL;
      "%":     k = K_MOD;
      ".":     k = K_DOT;
      ";":     k = K_SEMI;
      ":":     k = K_COLON;
      ",":     k = K_COMMA;
      default: k = K_END;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/stt_scan.sv -----
// Scanner state and per-character next-state and result logic.
// Depends on stt_pkg.
`default_nettype none

module stt_scan #(
  parameter int OFFSET_BITS   = 16,
  parameter int KEYWORD_CHARS = 8
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              take_i,
  input  stt_pkg::in_t     in_i,
  output stt_pkg::res_set_t res_o
);
  import stt_pkg::*;

  localparam int OW = OFFSET_BITS;
  localparam int PW = KEYWORD_CHARS * 8;

  mode_e           mode_q, mode_d;
  logic [OW-1:0]   pos_q, pos_d;
  logic [OW-1:0]   tbeg_q, tbeg_d;
  logic [PW-1:0]   prefix_q, prefix_d;
  logic [15:0]     wlen_q, wlen_d;
  logic [30:0]     acc_q, acc_d;
  logic            err_q, err_d;

  logic [7:0]      c;
  logic [OW:0]     p, pe;
  logic [3:0]      dig;
  logic [34:0]     v;
  logic            go_start;
  logic [3:0]      sv;
  out_t            so [4];
  logic [1:0]      n;
  res_set_t        rs;

  function automatic out_t mk_tok(logic [5:0] k, logic [OW:0] b, logic [OW:0] e,
                                  logic [30:0] val);
    out_t r;
    logic [32:0] bx, ex, ln;
    bx = 33'(b);
    ex = 33'(e);
    ln = (ex >= bx) ? ex - bx : '0;
    r.token_kind    = k;
    r.token_start   = sat16(bx);
    r.token_length  = sat16(ln);
    r.literal_value = val;
    r.error_code    = E_NONE;
    r.last_result   = 1'b0;
    return r;
  endfunction

  function automatic out_t mk_err(logic [2:0] e, logic [OW:0] w);
    out_t r;
    r = '0;
    r.token_start = sat16(33'(w));
    r.error_code  = e;
    return r;
  endfunction

  // next state and candidate results
  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    tbeg_d   = tbeg_q;
    prefix_d = prefix_q;
    wlen_d   = wlen_q;
    acc_d    = acc_q;
    err_d    = err_q;
    c        = in_i.character;
    p        = {1'b0, pos_q};
    pe       = p + 1'b1;
    dig      = c[3:0];
    v        = (35'(acc_q) << 3) + (35'(acc_q) << 1) + 35'(dig);
    go_start = 1'b0;
    sv       = '0;
    for (int i = 0; i < 4; i++) so[i] = '0;

    if (!err_q) begin
      // close or extend the pending token
      case (mode_q)
        M_MINUS: begin
          mode_d = M_IDLE;
          sv[0]  = 1'b1;
          if (c == ">") begin
            so[0] = mk_tok(K_ARROW, {1'b0, tbeg_q}, pe, '0);
          end else begin
            so[0] = mk_tok(K_SUB, {1'b0, tbeg_q}, p, '0);
            go_start = 1'b1;
          end
        end
        M_LT, M_GT, M_EQ, M_BANG: begin
          mode_d = M_IDLE;
          sv[0]  = 1'b1;
          if (c == "=") begin
            so[0] = mk_tok((mode_q == M_LT) ? K_LE : (mode_q == M_GT) ? K_GE :
                           (mode_q == M_EQ) ? K_EQEQ : K_NE, {1'b0, tbeg_q}, pe, '0);
          end else begin
            so[0] = mk_tok((mode_q == M_LT) ? K_LT : (mode_q == M_GT) ? K_GT :
                           (mode_q == M_EQ) ? K_ASSIGN : K_NOT, {1'b0, tbeg_q}, p, '0);
            go_start = 1'b1;
          end
        end
        M_AMP, M_BAR: begin
          mode_d = M_IDLE;
          sv[0]  = 1'b1;
          if ((mode_q == M_AMP && c == "&") || (mode_q == M_BAR && c == "|")) begin
            so[0] = mk_tok((mode_q == M_AMP) ? K_AND : K_OR, {1'b0, tbeg_q}, pe, '0);
          end else begin
            so[0] = mk_err(E_LONE, {1'b0, tbeg_q});
            err_d = 1'b1;
          end
        end
        M_SLASH: begin
          if (c == "/") begin
            mode_d = M_LINE;
          end else if (c == "*") begin
            mode_d = M_BLOCK;
          end else begin
            mode_d   = M_IDLE;
            sv[0]    = 1'b1;
            so[0]    = mk_tok(K_DIV, {1'b0, tbeg_q}, p, '0);
            go_start = 1'b1;
          end
        end
        M_LINE: begin
          if (c == 8'h0A) mode_d = M_IDLE;
        end
        M_BLOCK: begin
          if (c == "*") mode_d = M_BSTAR;
        end
        M_BSTAR: begin
          if (c == "/") mode_d = M_IDLE;
          else if (c != "*") mode_d = M_BLOCK;
        end
        M_NUM: begin
          if (is_digit(c)) begin
            if (v > 35'h7FFF_FFFF) begin
              mode_d = M_IDLE;
              sv[0]  = 1'b1;
              so[0]  = mk_err(E_OVF, {1'b0, tbeg_q});
              err_d  = 1'b1;
            end else begin
              acc_d = v[30:0];
            end
          end else begin
            mode_d   = M_IDLE;
            sv[0]    = 1'b1;
            so[0]    = mk_tok(K_INT, {1'b0, tbeg_q}, p, acc_q);
            go_start = 1'b1;
          end
        end
        M_WORD: begin
          if (is_alpha(c) || is_digit(c)) begin
            if (wlen_q < 16'(KEYWORD_CHARS)) prefix_d = {prefix_q[PW-9:0], c};
            if (wlen_q != 16'hFFFF) wlen_d = wlen_q + 16'd1;
          end else begin
            mode_d   = M_IDLE;
            sv[0]    = 1'b1;
            so[0]    = mk_tok(kw_kind(prefix_q[63:0], wlen_q), {1'b0, tbeg_q}, p, '0);
            go_start = 1'b1;
          end
        end
        default: begin
          mode_d   = M_IDLE;
          go_start = 1'b1;
        end
      endcase

      // character that begins something new
      if (go_start) begin
        tbeg_d = pos_q;
        if (is_space(c)) begin
          mode_d = M_IDLE;
        end else if (single_kind(c) != K_END) begin
          sv[1] = 1'b1;
          so[1] = mk_tok(single_kind(c), p, pe, '0);
        end else if (c == "-") begin
          mode_d = M_MINUS;
        end else if (c == "<") begin
          mode_d = M_LT;
        end else if (c == ">") begin
          mode_d = M_GT;
        end else if (c == "=") begin
          mode_d = M_EQ;
        end else if (c == "!") begin
          mode_d = M_BANG;
        end else if (c == "&") begin
          mode_d = M_AMP;
        end else if (c == "|") begin
          mode_d = M_BAR;
        end else if (c == "/") begin
          mode_d = M_SLASH;
        end else if (is_digit(c)) begin
          mode_d = M_NUM;
          acc_d  = 31'(dig);
        end else if (is_alpha(c)) begin
          mode_d   = M_WORD;
          prefix_d = PW'(c);
          wlen_d   = 16'd1;
        end else begin
          sv[1] = 1'b1;
          so[1] = mk_err(E_BAD, p);
          err_d = 1'b1;
        end
      end

      // end of text: flush pending token, then end word or error word
      if (!err_d && in_i.end_of_text) begin
        sv[3] = 1'b1;
        so[3] = mk_tok(K_END, pe, pe, '0);
        case (mode_d)
          M_MINUS: begin
            sv[2] = 1'b1;
            so[2] = mk_tok(K_SUB, {1'b0, tbeg_d}, pe, '0);
          end
          M_LT, M_GT, M_EQ, M_BANG: begin
            sv[2] = 1'b1;
            so[2] = mk_tok((mode_d == M_LT) ? K_LT : (mode_d == M_GT) ? K_GT :
                           (mode_d == M_EQ) ? K_ASSIGN : K_NOT, {1'b0, tbeg_d}, pe, '0);
          end
          M_AMP, M_BAR: begin
            so[3] = mk_err(E_LONE, {1'b0, tbeg_d});
          end
          M_SLASH: begin
            sv[2] = 1'b1;
            so[2] = mk_tok(K_DIV, {1'b0, tbeg_d}, pe, '0);
          end
          M_BLOCK, M_BSTAR: begin
            so[3] = mk_err(E_OPEN, {1'b0, tbeg_d});
          end
          M_NUM: begin
            sv[2] = 1'b1;
            so[2] = mk_tok(K_INT, {1'b0, tbeg_d}, pe, acc_d);
          end
          M_WORD: begin
            sv[2] = 1'b1;
            so[2] = mk_tok(kw_kind(prefix_d[63:0], wlen_d), {1'b0, tbeg_d}, pe, '0);
          end
          default: ;
        endcase
      end
    end

    // position and restart
    if (in_i.end_of_text) begin
      mode_d   = M_IDLE;
      pos_d    = '0;
      tbeg_d   = '0;
      prefix_d = '0;
      wlen_d   = '0;
      acc_d    = '0;
      err_d    = 1'b0;
    end else if (pos_q != '1) begin
      pos_d = pos_q + 1'b1;
    end
  end

  // pack the candidates in order and flag the final one
  always_comb begin
    rs = '0;
    n  = '0;
    for (int i = 0; i < 4; i++) begin
      if (sv[i] && n != 2'd3) begin
        rs.res[n] = so[i];
        n = n + 2'd1;
      end
    end
    if (n != 2'd0) rs.res[n - 2'd1].last_result = 1'b1;
    rs.cnt = n;
  end

  assign res_o = rs;

  // scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      pos_q    <= '0;
      tbeg_q   <= '0;
      prefix_q <= '0;
      wlen_q   <= '0;
      acc_q    <= '0;
      err_q    <= 1'b0;
    end else if (take_i) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      tbeg_q   <= tbeg_d;
      prefix_q <= prefix_d;
      wlen_q   <= wlen_d;
      acc_q    <= acc_d;
      err_q    <= err_d;
    end
  end

  // an error state never coexists with an open token
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> mode_q != M_NUM && mode_q != M_WORD && mode_q != M_AMP && mode_q != M_BAR)
    else $error("latched error with open token");
  // a word in progress never has zero length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == M_WORD) |-> wlen_q != 16'd0)
    else $error("word with zero length");
  // the final character always restarts at offset zero with no error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && in_i.end_of_text) |=> pos_q == '0 && !err_q)
    else $error("text not restarted");

endmodule

`default_nettype wire

// ----- hdl/source_text_tokenizer_unit.sv -----
// Results of a character are valid the cycle after it is accepted.
// Throughput: one character per cycle while each yields at most one word
//   and no output stall; other characters hold the input while the single
//   output port drains the three-entry result register to the last word.
// Reset: asynchronous, active low; scanner idle at offset zero, result empty.
// Top level of the tokenizer; depends on stt_pkg and stt_scan.
`default_nettype none

module source_text_tokenizer_unit #(
  parameter int OFFSET_BITS   = stt_pkg::OFFSET_BITS_DEF,
  parameter int KEYWORD_CHARS = stt_pkg::KEYWORD_CHARS_DEF
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           in_valid_i,
  output logic          in_stall_o,
  input  stt_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  wire           out_stall_i,
  output stt_pkg::out_t out_data_o
);
  import stt_pkg::*;

  res_set_t   rs;
  out_t       res_q [3];
  logic [1:0] cnt_q;
  logic [1:0] rd_q;
  logic       take;
  logic       pop;

  stt_scan #(
    .OFFSET_BITS  (OFFSET_BITS),
    .KEYWORD_CHARS(KEYWORD_CHARS)
  ) u_scan (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .take_i(take),
    .in_i  (in_data_i),
    .res_o (rs)
  );

  // handshake
  assign out_valid_o = cnt_q != 2'd0;
  assign pop         = out_valid_o && !out_stall_i;
  assign in_stall_o  = !(cnt_q == 2'd0 || (cnt_q == 2'd1 && !out_stall_i));
  assign take        = in_valid_i && !in_stall_o;
  assign out_data_o  = res_q[rd_q];

  // result payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      for (int i = 0; i < 3; i++) res_q[i] <= rs.res[i];
    end
  end

  // result count and read index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (take) begin
      cnt_q <= rs.cnt;
      rd_q  <= '0;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
      rd_q  <= rd_q + 2'd1;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (3'(rd_q) + 3'(cnt_q)) <= 3'd3)
    else $error("result index beyond buffer");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_result == (cnt_q == 2'd1)))
    else $error("last flag misplaced");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.error_code != E_NONE) |->
      (out_data_o.token_kind == K_END && out_data_o.token_length == 16'd0))
    else $error("error word carries a token");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && rs.cnt == 2'd0) |=> !out_valid_o)
    else $error("empty character produced a word");

endmodule

`default_nettype wire
